>>> hdl/tzd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-zone designator parser package
// Shared types, phase and status codes, and the zone name table.
// ----------------------------------------------------------------------------
package tzd_pkg;

    // Parse phases.
    localparam logic [2:0] PH_SKIP  = 3'd0;
    localparam logic [2:0] PH_NAME  = 3'd1;
    localparam logic [2:0] PH_AFTER = 3'd2;
    localparam logic [2:0] PH_HOURS = 3'd3;
    localparam logic [2:0] PH_COLON = 3'd4;
    localparam logic [2:0] PH_MIN   = 3'd5;
    localparam logic [2:0] PH_DONE  = 3'd6;

    // Result status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_UNKNOWN     = 3'd1;
    localparam logic [2:0] ST_FORBIDDEN   = 3'd2;
    localparam logic [2:0] ST_NO_HOURS    = 3'd3;
    localparam logic [2:0] ST_HOURS_RANGE = 3'd4;
    localparam logic [2:0] ST_NO_MINUTES  = 3'd5;
    localparam logic [2:0] ST_MIN_RANGE   = 3'd6;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam logic [6:0] MAX_HOURS   = 7'd23;
    localparam logic [6:0] MAX_MINUTES = 7'd59;

    localparam int ZONE_COUNT = 34;

    typedef struct packed {
        logic [31:0]        letters;
        logic [2:0]         len;
        logic signed [16:0] base;
        logic               shift;
    } zone_entry_t;

    typedef struct packed {
        logic               hit;
        logic signed [16:0] base;
        logic               shift;
    } zone_t;

    typedef struct packed {
        logic               valid;
        logic signed [17:0] offset_seconds;
        logic [2:0]         status;
        logic [7:0]         consumed_chars;
    } result_t;

    localparam zone_entry_t ZONE_TABLE [ZONE_COUNT] = '{
        '{{24'd0, "Z"},    3'd1, 17'sd0,      1'b1},
        '{{16'd0, "UT"},   3'd2, 17'sd0,      1'b1},
        '{{8'd0, "GMT"},   3'd3, 17'sd0,      1'b1},
        '{{8'd0, "BST"},   3'd3, 17'sd3600,   1'b0},
        '{{8'd0, "IST"},   3'd3, 17'sd3600,   1'b0},
        '{{8'd0, "WET"},   3'd3, 17'sd0,      1'b0},
        '{"WEST",          3'd4, 17'sd3600,   1'b0},
        '{{8'd0, "CET"},   3'd3, 17'sd3600,   1'b0},
        '{"CEST",          3'd4, 17'sd7200,   1'b0},
        '{{8'd0, "EET"},   3'd3, 17'sd7200,   1'b0},
        '{"EEST",          3'd4, 17'sd10800,  1'b0},
        '{{8'd0, "MSK"},   3'd3, 17'sd10800,  1'b0},
        '{{8'd0, "MSD"},   3'd3, 17'sd14400,  1'b0},
        '{{8'd0, "NST"},   3'd3, -17'sd12600, 1'b0},
        '{{8'd0, "NDT"},   3'd3, -17'sd9000,  1'b0},
        '{{8'd0, "AST"},   3'd3, -17'sd14400, 1'b0},
        '{{8'd0, "ADT"},   3'd3, -17'sd10800, 1'b0},
        '{{8'd0, "EST"},   3'd3, -17'sd18000, 1'b0},
        '{{8'd0, "EDT"},   3'd3, -17'sd14400, 1'b0},
        '{{8'd0, "CST"},   3'd3, -17'sd21600, 1'b0},
        '{{8'd0, "CDT"},   3'd3, -17'sd18000, 1'b0},
        '{{8'd0, "MST"},   3'd3, -17'sd25200, 1'b0},
        '{{8'd0, "MDT"},   3'd3, -17'sd21600, 1'b0},
        '{{8'd0, "PST"},   3'd3, -17'sd28800, 1'b0},
        '{{8'd0, "PDT"},   3'd3, -17'sd25200, 1'b0},
        '{"AKST",          3'd4, -17'sd32400, 1'b0},
        '{"AKDT",          3'd4, -17'sd28800, 1'b0},
        '{{8'd0, "HST"},   3'd3, -17'sd36000, 1'b0},
        '{"AEST",          3'd4, 17'sd36000,  1'b0},
        '{"AEDT",          3'd4, 17'sd39600,  1'b0},
        '{"ACST",          3'd4, 17'sd34200,  1'b0},
        '{"ACDT",          3'd4, 17'sd37800,  1'b0},
        '{"AWST",          3'd4, 17'sd28800,  1'b0},
        '{"AWDT",          3'd4, 17'sd32400,  1'b0}
    };

endpackage

>>> hdl/tzd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-zone designator parser channels
// Valid/ready interfaces for the character input and the result output.
// ----------------------------------------------------------------------------
interface tzd_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       final_char;

    modport source (output valid, output char_code, output final_char, input ready);
    modport sink (input valid, input char_code, input final_char, output ready);
endinterface

interface tzd_result_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] offset_seconds;
    logic [2:0]         status;
    logic [7:0]         consumed_chars;

    modport source (output valid, output offset_seconds, output status,
                    output consumed_chars, input ready);
    modport sink (input valid, input offset_seconds, input status,
                  input consumed_chars, output ready);
endinterface

>>> hdl/tzd_zone_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zone name lookup
// Case-sensitive match of the collected letters against the zone table.
// ----------------------------------------------------------------------------
module tzd_zone_lookup
(
    input  logic [31:0]    name,
    input  logic [2:0]     count,
    output tzd_pkg::zone_t zone
);

    // Names in the table are unique, so at most one entry matches.
    always_comb
    begin
        zone = '0;
        for (int i = 0; i < tzd_pkg::ZONE_COUNT; i++)
        begin
            if (tzd_pkg::ZONE_TABLE[i].len == count &&
                tzd_pkg::ZONE_TABLE[i].letters == name)
            begin
                zone.hit   = 1'b1;
                zone.base  = tzd_pkg::ZONE_TABLE[i].base;
                zone.shift = tzd_pkg::ZONE_TABLE[i].shift;
            end
        end
    end

endmodule

>>> hdl/tzd_parse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parse core
// Parse state registers and the combinational step for one character.
// ----------------------------------------------------------------------------
module tzd_parse_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [7:0]        char_code,
    input  logic              final_char,
    output tzd_pkg::result_t  result
);

    logic [2:0]         phase_reg,   phase_next;
    logic [31:0]        name_reg,    name_next;
    logic [2:0]         letters_reg, letters_next;
    logic signed [16:0] base_reg,    base_next;
    logic               shift_reg,   shift_next;
    logic               neg_reg,     neg_next;
    logic [6:0]         hour_reg,    hour_next;
    logic [1:0]         hdig_reg,    hdig_next;
    logic [6:0]         min_reg,     min_next;
    logic [1:0]         mdig_reg,    mdig_next;
    logic [7:0]         count_reg,   count_next;

    logic               is_space;
    logic               is_alpha;
    logic               is_digit;
    logic               is_sign;
    logic [3:0]         digit;
    logic [31:0]        name_upd;
    logic [2:0]         letters_upd;
    tzd_pkg::zone_t     zone;
    logic               emit_valid;
    logic [2:0]         emit_status;
    logic               do_after;
    logic               do_minute;
    logic [17:0]        magnitude;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    assign is_space = (char_code == 8'h20) || (char_code >= 8'h09 && char_code <= 8'h0D);
    assign is_alpha = (char_code >= 8'h41 && char_code <= 8'h5A) ||
                      (char_code >= 8'h61 && char_code <= 8'h7A);
    assign is_digit = (char_code >= 8'h30 && char_code <= 8'h39);
    assign is_sign  = (char_code == tzd_pkg::CH_PLUS) || (char_code == tzd_pkg::CH_MINUS);
    assign digit    = 4'(char_code - tzd_pkg::CH_ZERO);

    // Every lookup of a step sees the letters after this character is added,
    // if it is a letter of the name.
    always_comb
    begin
        if (is_alpha && (phase_reg == tzd_pkg::PH_SKIP || phase_reg == tzd_pkg::PH_NAME))
        begin
            name_upd    = {name_reg[23:0], char_code};
            letters_upd = letters_reg + 3'd1;
        end
        else
        begin
            name_upd    = name_reg;
            letters_upd = letters_reg;
        end
    end

    tzd_zone_lookup u_lookup
    (
        .name  (name_upd),
        .count (letters_upd),
        .zone  (zone)
    );

    always_comb
    begin
        phase_next   = phase_reg;
        name_next    = name_reg;
        letters_next = letters_reg;
        base_next    = base_reg;
        shift_next   = shift_reg;
        neg_next     = neg_reg;
        hour_next    = hour_reg;
        hdig_next    = hdig_reg;
        min_next     = min_reg;
        mdig_next    = mdig_reg;
        count_next   = count_reg;
        emit_valid   = 1'b0;
        emit_status  = tzd_pkg::ST_OK;
        do_after     = 1'b0;
        do_minute    = 1'b0;

        unique case (phase_reg)
            tzd_pkg::PH_SKIP,
            tzd_pkg::PH_NAME:
            begin
                if (phase_reg == tzd_pkg::PH_SKIP && is_space)
                begin
                    count_next = sat_inc(count_reg);
                end
                else if (is_alpha)
                begin
                    count_next   = sat_inc(count_reg);
                    name_next    = name_upd;
                    letters_next = letters_upd;
                    phase_next   = tzd_pkg::PH_NAME;
                    if (letters_upd >= 3'd4)
                    begin
                        if (!zone.hit)
                        begin
                            emit_valid  = 1'b1;
                            emit_status = tzd_pkg::ST_UNKNOWN;
                        end
                        else
                        begin
                            base_next  = zone.base;
                            shift_next = zone.shift;
                            phase_next = tzd_pkg::PH_AFTER;
                        end
                    end
                end
                else if (phase_reg == tzd_pkg::PH_SKIP)
                begin
                    // No designator: a zone of offset zero that allows a difference.
                    base_next  = '0;
                    shift_next = 1'b1;
                    phase_next = tzd_pkg::PH_AFTER;
                    do_after   = 1'b1;
                end
                else if (!zone.hit)
                begin
                    emit_valid  = 1'b1;
                    emit_status = tzd_pkg::ST_UNKNOWN;
                end
                else
                begin
                    base_next  = zone.base;
                    shift_next = zone.shift;
                    phase_next = tzd_pkg::PH_AFTER;
                    do_after   = 1'b1;
                end
            end
            tzd_pkg::PH_AFTER:
            begin
                do_after = 1'b1;
            end
            tzd_pkg::PH_HOURS:
            begin
                if (is_digit)
                begin
                    count_next = sat_inc(count_reg);
                    hour_next  = 7'(hour_reg * 7'd10 + {3'd0, digit});
                    hdig_next  = hdig_reg + 2'd1;
                    if (hdig_next >= 2'd2)
                    begin
                        if (hour_next > tzd_pkg::MAX_HOURS)
                        begin
                            emit_valid  = 1'b1;
                            emit_status = tzd_pkg::ST_HOURS_RANGE;
                        end
                        else
                        begin
                            phase_next = tzd_pkg::PH_COLON;
                        end
                    end
                end
                else if (hdig_reg == 2'd0)
                begin
                    emit_valid  = 1'b1;
                    emit_status = tzd_pkg::ST_NO_HOURS;
                end
                else if (char_code == tzd_pkg::CH_COLON)
                begin
                    count_next = sat_inc(count_reg);
                    phase_next = tzd_pkg::PH_MIN;
                end
                else
                begin
                    emit_valid  = 1'b1;
                    emit_status = tzd_pkg::ST_NO_MINUTES;
                end
            end
            tzd_pkg::PH_COLON:
            begin
                phase_next = tzd_pkg::PH_MIN;
                if (char_code == tzd_pkg::CH_COLON)
                begin
                    count_next = sat_inc(count_reg);
                end
                else
                begin
                    do_minute = 1'b1;
                end
            end
            tzd_pkg::PH_MIN:
            begin
                do_minute = 1'b1;
            end
            default:
            begin
                // Done: characters up to the end of the field are ignored.
            end
        endcase

        if (do_after)
        begin
            if (is_sign && !shift_next)
            begin
                emit_valid  = 1'b1;
                emit_status = tzd_pkg::ST_FORBIDDEN;
            end
            else if (is_sign)
            begin
                count_next = sat_inc(count_reg);
                neg_next   = (char_code == tzd_pkg::CH_MINUS);
                phase_next = tzd_pkg::PH_HOURS;
            end
            else
            begin
                emit_valid  = 1'b1;
                emit_status = tzd_pkg::ST_OK;
            end
        end

        if (do_minute)
        begin
            if (is_digit)
            begin
                count_next = sat_inc(count_reg);
                min_next   = 7'(min_reg * 7'd10 + {3'd0, digit});
                mdig_next  = mdig_reg + 2'd1;
                if (mdig_next >= 2'd2)
                begin
                    emit_valid  = 1'b1;
                    emit_status = (min_next > tzd_pkg::MAX_MINUTES) ?
                                  tzd_pkg::ST_MIN_RANGE : tzd_pkg::ST_OK;
                end
            end
            else
            begin
                emit_valid  = 1'b1;
                emit_status = (mdig_reg == 2'd0) ? tzd_pkg::ST_NO_MINUTES : tzd_pkg::ST_OK;
            end
        end

        if (emit_valid)
        begin
            phase_next = tzd_pkg::PH_DONE;
        end

        // The end of the field acts like a terminating character.
        if (final_char && !emit_valid)
        begin
            unique case (phase_next)
                tzd_pkg::PH_SKIP:
                begin
                    emit_valid  = 1'b1;
                    emit_status = tzd_pkg::ST_OK;
                    base_next   = '0;
                end
                tzd_pkg::PH_NAME:
                begin
                    emit_valid = 1'b1;
                    if (zone.hit)
                    begin
                        emit_status = tzd_pkg::ST_OK;
                        base_next   = zone.base;
                    end
                    else
                    begin
                        emit_status = tzd_pkg::ST_UNKNOWN;
                    end
                end
                tzd_pkg::PH_AFTER:
                begin
                    emit_valid  = 1'b1;
                    emit_status = tzd_pkg::ST_OK;
                end
                tzd_pkg::PH_HOURS:
                begin
                    emit_valid  = 1'b1;
                    emit_status = (hdig_next == 2'd0) ?
                                  tzd_pkg::ST_NO_HOURS : tzd_pkg::ST_NO_MINUTES;
                end
                tzd_pkg::PH_COLON:
                begin
                    emit_valid  = 1'b1;
                    emit_status = tzd_pkg::ST_NO_MINUTES;
                end
                tzd_pkg::PH_MIN:
                begin
                    emit_valid  = 1'b1;
                    emit_status = (mdig_next == 2'd0) ? tzd_pkg::ST_NO_MINUTES : tzd_pkg::ST_OK;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign magnitude = 18'({11'd0, hour_next} * 18'd3600) + 18'({11'd0, min_next} * 18'd60);

    always_comb
    begin
        result.valid          = emit_valid;
        result.status         = emit_status;
        result.consumed_chars = count_next;
        if (emit_status == tzd_pkg::ST_OK)
        begin
            result.offset_seconds = 18'({base_next[16], base_next}) +
                                    (neg_next ? -magnitude : magnitude);
        end
        else
        begin
            result.offset_seconds = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= tzd_pkg::PH_SKIP;
            name_reg    <= '0;
            letters_reg <= '0;
            base_reg    <= '0;
            shift_reg   <= 1'b0;
            neg_reg     <= 1'b0;
            hour_reg    <= '0;
            hdig_reg    <= '0;
            min_reg     <= '0;
            mdig_reg    <= '0;
            count_reg   <= '0;
        end
        else if (step_en)
        begin
            if (final_char)
            begin
                phase_reg   <= tzd_pkg::PH_SKIP;
                name_reg    <= '0;
                letters_reg <= '0;
                base_reg    <= '0;
                shift_reg   <= 1'b0;
                neg_reg     <= 1'b0;
                hour_reg    <= '0;
                hdig_reg    <= '0;
                min_reg     <= '0;
                mdig_reg    <= '0;
                count_reg   <= '0;
            end
            else
            begin
                phase_reg   <= phase_next;
                name_reg    <= name_next;
                letters_reg <= letters_next;
                base_reg    <= base_next;
                shift_reg   <= shift_next;
                neg_reg     <= neg_next;
                hour_reg    <= hour_next;
                hdig_reg    <= hdig_next;
                min_reg     <= min_next;
                mdig_reg    <= mdig_next;
                count_reg   <= count_next;
            end
        end
    end

    // An error result never carries an offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status != tzd_pkg::ST_OK |-> result.offset_seconds == '0)
    else $error("error result with nonzero offset");

    // A field that has not yet reported gives its result at the latest on its last word.
    assert property (@(posedge clk) disable iff (!rst_n)
        step_en && final_char && phase_reg != tzd_pkg::PH_DONE |-> result.valid)
    else $error("field ended without a result");

    // Once a field has reported, no second result appears.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == tzd_pkg::PH_DONE |-> !result.valid)
    else $error("second result for one field");

    // The last word of a field returns the parser to its idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        step_en && final_char |=> phase_reg == tzd_pkg::PH_SKIP && count_reg == '0)
    else $error("parser not cleared after end of field");

endmodule

>>> hdl/time_zone_designator_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-zone designator parser
// Parses a zone field such as "GMT+05:30" or "PDT" into an offset in seconds.
// ----------------------------------------------------------------------------
// Usage:
//   chars   - one character word per cycle; final_char marks the last one of
//             a field. Leading white space is skipped.
//   results - one word per field: offset_seconds, status and consumed_chars.
//             The result appears as soon as the parse ends, which may be
//             before the end of the field; later characters are dropped.
// Path: the character that ends the parse is first captured in the input
//   register; once the result register has room, the parse step loads the
//   result register from it and results.valid rises.
// Throughput: one character per cycle unless a result stalls; the whole parse
//   step of a character fits in the single stage between input and result registers.
// Reset: clears the valid flags of both registers and returns the parser to the
//   start of a field. The end of each field returns the parser there as well.
// Stall: while a result waits on results.ready, the input register holds
//   one more character and chars.ready drops only once that register is full.
// ----------------------------------------------------------------------------
module time_zone_designator_parser
(
    input logic          clk,
    input logic          rst_n,
    tzd_char_if.sink     chars,
    tzd_result_if.source results
);

    logic               in_valid_reg;
    logic [7:0]         char_reg;
    logic               final_reg;
    logic               out_valid_reg;
    logic signed [17:0] offset_reg;
    logic [2:0]         status_reg;
    logic [7:0]         consumed_reg;
    logic               advance;
    tzd_pkg::result_t   result;

    // The held character moves into the parser only when the result register
    // has room for whatever it may produce.
    assign advance     = in_valid_reg && (!out_valid_reg || results.ready);
    assign chars.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            in_valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            char_reg  <= chars.char_code;
            final_reg <= chars.final_char;
        end
    end

    tzd_parse_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (advance),
        .char_code  (char_reg),
        .final_char (final_reg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && result.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.valid)
        begin
            offset_reg   <= result.offset_seconds;
            status_reg   <= result.status;
            consumed_reg <= result.consumed_chars;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.offset_seconds = offset_reg;
    assign results.status         = status_reg;
    assign results.consumed_chars = consumed_reg;

    // A stalled result blocks the parser, so a held character cannot advance.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !results.ready |-> !advance)
    else $error("parser advanced over a stalled result");

    // A result produced by the parser is visible on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.valid |=> results.valid)
    else $error("parser result was lost");

    // The input side is refused only while a character is held and blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        !chars.ready |-> in_valid_reg && out_valid_reg && !results.ready)
    else $error("input refused without a stall");

endmodule
